// ===== rtl/core/biquad_highpass_filter_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Biquad high-pass filter assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef BIQUAD_HIGHPASS_FILTER_UNIT_MACROS_SVH
`define BIQUAD_HIGHPASS_FILTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bhp_pkg.sv =====
// ---------------------------------------------------------------------------
// Biquad high-pass filter package
// Widths, register map, reset values and types shared by the filter files.
// ---------------------------------------------------------------------------
package bhp_pkg;

	// Sample and fixed-point formats.
	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;
	localparam int COEF_FRAC   = 30;
	localparam int GAIN_BITS   = 31;
	localparam int COEF_BITS   = 34;
	localparam int X_BITS      = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int Y_BITS      = SAMPLE_BITS + FRAC_BITS + 8;
	localparam int SCALE_SHIFT = COEF_FRAC - FRAC_BITS;

	// Shared multiplier: coefficient times one half of a history word.
	localparam int HALF_BITS  = Y_BITS / 2;
	localparam int MUL_A_BITS = COEF_BITS + 1;
	localparam int MUL_B_BITS = HALF_BITS + 1;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
	localparam int ACC_BITS   = PROD_BITS + HALF_BITS;
	localparam int Q_BITS     = Y_BITS - FRAC_BITS + 1;

	// Configuration port.
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_ADDR_BITS = 5;
	localparam int REG_IDX_BITS  = 2;

	typedef logic [REG_IDX_BITS-1:0]      reg_idx_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [GAIN_BITS-1:0]          gain_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [X_BITS-1:0]      xhist_t;
	typedef logic signed [Y_BITS-1:0]      yhist_t;
	typedef logic signed [MUL_A_BITS-1:0]  mul_a_t;
	typedef logic signed [MUL_B_BITS-1:0]  mul_b_t;
	typedef logic signed [PROD_BITS-1:0]   prod_t;
	typedef logic signed [ACC_BITS-1:0]    acc_t;
	typedef logic signed [Q_BITS-1:0]      qval_t;

	// Register map, by index; byte address is eight times the index.
	localparam reg_idx_t REG_GAIN    = 2'd0;
	localparam reg_idx_t REG_COEF_Y1 = 2'd1;
	localparam reg_idx_t REG_COEF_Y2 = 2'd2;

	// Register reset values.
	localparam gain_t GAIN_RESET    = 31'd1072549859;
	localparam coef_t COEF_Y1_RESET = 34'sd2145098399;
	localparam coef_t COEF_Y2_RESET = -34'sd1071359221;

	// Result limits.
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam yhist_t  Y_MAX      = {1'b0, {(Y_BITS-1){1'b1}}};
	localparam yhist_t  Y_MIN      = {1'b1, {(Y_BITS-1){1'b0}}};

endpackage

// ===== rtl/core/bhp_if.sv =====
// ---------------------------------------------------------------------------
// Biquad high-pass filter channels
// Valid/ready channels for input samples and filtered results.
// ---------------------------------------------------------------------------
interface bhp_in_if;
	logic             valid;
	logic             ready;
	bhp_pkg::sample_t sample_in;
	logic             packet_end;
	logic             keep_history;

	modport source (output valid, sample_in, packet_end, keep_history, input ready);
	modport sink (input valid, sample_in, packet_end, keep_history, output ready);
endinterface

interface bhp_out_if;
	logic             valid;
	logic             ready;
	bhp_pkg::sample_t filtered_out;
	logic             saturated;
	logic             packet_end_out;

	modport source (output valid, filtered_out, saturated, packet_end_out, input ready);
	modport sink (input valid, filtered_out, saturated, packet_end_out, output ready);
endinterface

// ===== rtl/core/biquad_highpass_filter_unit.sv =====
// ---------------------------------------------------------------------------
// Biquad high-pass filter unit
// Second-order high-pass recursion on seismic samples with one shared
// multiplier and accumulator under a step sequencer.
// ---------------------------------------------------------------------------
// Usage:
// sample_ch carries one request per sample (sample_in, packet_end,
// keep_history); result_ch returns one filtered sample per request with a
// saturation flag and a copy of packet_end. Coefficients are loaded through
// the APB port at byte addresses 0 (gain), 8 (c1) and 16 (c2).
// After a request is accepted, a result takes five passes through the
// shared 35x25 multiplier, one accumulator add per cycle, then a
// narrowing step and a rounding step. The unit takes one request at a
// time, so a new sample is accepted only once the sequencer is idle again.
// sample_ch.ready is high only while the sequencer idles; a finished
// result sits in the output register, so the next request can be accepted
// while it waits. If the receiver stalls and a second result is ready, the
// sequencer holds in its last step until the register frees.
// Reset loads the default coefficients and clears all history words.
// A packet-end sample without keep_history clears history after its result.
// ---------------------------------------------------------------------------
`include "biquad_highpass_filter_unit_macros.svh"

module biquad_highpass_filter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [bhp_pkg::CFG_ADDR_BITS-1:0]    paddr,
	input  logic [bhp_pkg::CFG_DATA_BITS-1:0]    pwdata,
	output logic [bhp_pkg::CFG_DATA_BITS-1:0]    prdata,
	output logic                                 pready,
	bhp_in_if.sink                               sample_ch,
	bhp_out_if.source                            result_ch
);

	// Sequencer steps.
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_MUL_X   = 4'd1;
	localparam logic [3:0] ST_MUL_Y2L = 4'd2;
	localparam logic [3:0] ST_MUL_Y2H = 4'd3;
	localparam logic [3:0] ST_MUL_Y1L = 4'd4;
	localparam logic [3:0] ST_MUL_Y1H = 4'd5;
	localparam logic [3:0] ST_ACC_Y1L = 4'd6;
	localparam logic [3:0] ST_ACC_Y1H = 4'd7;
	localparam logic [3:0] ST_NARROW  = 4'd8;
	localparam logic [3:0] ST_ROUND   = 4'd9;

	logic [3:0]        state_q;
	logic [3:0]        state_d;

	bhp_pkg::gain_t    gain_q;
	bhp_pkg::coef_t    coef_y1_q;
	bhp_pkg::coef_t    coef_y2_q;
	bhp_pkg::xhist_t   x_hist1_q;
	bhp_pkg::xhist_t   x_hist2_q;
	bhp_pkg::yhist_t   y_hist1_q;
	bhp_pkg::yhist_t   y_hist2_q;

	bhp_pkg::sample_t  sample_q;
	logic              pend_q;
	logic              keep_q;
	bhp_pkg::prod_t    prod_q;
	bhp_pkg::acc_t     acc_q;
	bhp_pkg::xhist_t   xn_q;
	bhp_pkg::yhist_t   yn_q;

	logic              out_valid_q;
	bhp_pkg::sample_t  filt_q;
	logic              sat_q;
	logic              pend_out_q;

	logic              accept;
	logic              out_free;
	logic              finish;
	logic              cfg_we;
	bhp_pkg::reg_idx_t cfg_idx;

	bhp_pkg::mul_a_t   mul_a;
	bhp_pkg::mul_b_t   mul_b;
	bhp_pkg::prod_t    prod_d;
	bhp_pkg::acc_t     addend;
	logic              acc_sub;
	bhp_pkg::acc_t     acc_sum;
	bhp_pkg::acc_t     acc_init;
	bhp_pkg::xhist_t   xn_d;
	bhp_pkg::acc_t     acc_shifted;
	logic [bhp_pkg::ACC_BITS-bhp_pkg::Y_BITS:0] acc_top;
	bhp_pkg::yhist_t   yn_d;
	bhp_pkg::qval_t    q_base;
	bhp_pkg::qval_t    q_rnd;
	logic [bhp_pkg::Q_BITS-bhp_pkg::SAMPLE_BITS:0] q_top;
	logic              q_fits;
	bhp_pkg::sample_t  res_d;

	// Handshakes.
	assign sample_ch.ready = (state_q == ST_IDLE);
	assign accept          = sample_ch.valid && (state_q == ST_IDLE);
	assign out_free        = !out_valid_q || result_ch.ready;
	assign finish          = (state_q == ST_ROUND) && out_free;

	assign result_ch.valid          = out_valid_q;
	assign result_ch.filtered_out   = filt_q;
	assign result_ch.saturated      = sat_q;
	assign result_ch.packet_end_out = pend_out_q;

	// Configuration port decode.
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = paddr[bhp_pkg::CFG_ADDR_BITS-1:bhp_pkg::CFG_ADDR_BITS-bhp_pkg::REG_IDX_BITS];

	always_comb begin
		unique case (cfg_idx)
			bhp_pkg::REG_GAIN:    prdata = bhp_pkg::CFG_DATA_BITS'(gain_q);
			bhp_pkg::REG_COEF_Y1: prdata = bhp_pkg::CFG_DATA_BITS'(coef_y1_q);
			bhp_pkg::REG_COEF_Y2: prdata = bhp_pkg::CFG_DATA_BITS'(coef_y2_q);
			default:              prdata = '0;
		endcase
	end

	// Sequencer: one step per cycle, holding in the last step while the
	// output register is still occupied.
	always_comb begin
		unique case (state_q)
			ST_IDLE:    state_d = accept ? ST_MUL_X : ST_IDLE;
			ST_MUL_X:   state_d = ST_MUL_Y2L;
			ST_MUL_Y2L: state_d = ST_MUL_Y2H;
			ST_MUL_Y2H: state_d = ST_MUL_Y1L;
			ST_MUL_Y1L: state_d = ST_MUL_Y1H;
			ST_MUL_Y1H: state_d = ST_ACC_Y1L;
			ST_ACC_Y1L: state_d = ST_ACC_Y1H;
			ST_ACC_Y1H: state_d = ST_NARROW;
			ST_NARROW:  state_d = ST_ROUND;
			ST_ROUND:   state_d = out_free ? ST_IDLE : ST_ROUND;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Shared multiplier operands: the gain product first, then each
	// coefficient against the low and high halves of its history word.
	always_comb begin
		unique case (state_q)
			ST_MUL_X: begin
				mul_a = bhp_pkg::mul_a_t'({1'b0, gain_q});
				mul_b = bhp_pkg::mul_b_t'(sample_q);
			end
			ST_MUL_Y2L: begin
				mul_a = bhp_pkg::mul_a_t'(coef_y2_q);
				mul_b = {1'b0, y_hist2_q[bhp_pkg::HALF_BITS-1:0]};
			end
			ST_MUL_Y2H: begin
				mul_a = bhp_pkg::mul_a_t'(coef_y2_q);
				mul_b = bhp_pkg::mul_b_t'(y_hist2_q[bhp_pkg::Y_BITS-1:bhp_pkg::HALF_BITS]);
				mul_b[bhp_pkg::MUL_B_BITS-1] = y_hist2_q[bhp_pkg::Y_BITS-1];
			end
			ST_MUL_Y1L: begin
				mul_a = bhp_pkg::mul_a_t'(coef_y1_q);
				mul_b = {1'b0, y_hist1_q[bhp_pkg::HALF_BITS-1:0]};
			end
			ST_MUL_Y1H: begin
				mul_a = bhp_pkg::mul_a_t'(coef_y1_q);
				mul_b = bhp_pkg::mul_b_t'(y_hist1_q[bhp_pkg::Y_BITS-1:bhp_pkg::HALF_BITS]);
				mul_b[bhp_pkg::MUL_B_BITS-1] = y_hist1_q[bhp_pkg::Y_BITS-1];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = bhp_pkg::PROD_BITS'(mul_a * mul_b);

	// Accumulator addend; each registered product is added in the step after
	// its multiply, and the scaled input goes in once the last product is in.
	always_comb begin
		acc_sub = 1'b0;
		case (state_q) inside
			ST_MUL_Y2L: begin
				addend  = bhp_pkg::acc_t'(x_hist1_q) <<< (bhp_pkg::COEF_FRAC + 1);
				acc_sub = 1'b1;
			end
			ST_MUL_Y2H, ST_MUL_Y1H: addend = bhp_pkg::acc_t'(prod_q);
			ST_MUL_Y1L, ST_ACC_Y1L: addend = bhp_pkg::acc_t'(prod_q) <<< bhp_pkg::HALF_BITS;
			ST_ACC_Y1H: addend = bhp_pkg::acc_t'(xn_q) <<< bhp_pkg::COEF_FRAC;
			default: addend = '0;
		endcase
	end

	assign acc_sum = acc_q + (addend ^ {bhp_pkg::ACC_BITS{acc_sub}})
		+ bhp_pkg::acc_t'(acc_sub);

	// Start value: x[n-2] in coefficient scale plus the rounding half.
	assign acc_init = (bhp_pkg::acc_t'(x_hist2_q) <<< bhp_pkg::COEF_FRAC)
		| (bhp_pkg::acc_t'(1) <<< (bhp_pkg::COEF_FRAC - 1));

	// Scaled input, rounded half up into the history format.
	assign xn_d = bhp_pkg::X_BITS'((prod_q + (bhp_pkg::prod_t'(1) <<< (bhp_pkg::SCALE_SHIFT - 1)))
		>>> bhp_pkg::SCALE_SHIFT);

	// New output back in history scale, saturated to the history width.
	assign acc_shifted = acc_q >>> bhp_pkg::COEF_FRAC;
	assign acc_top     = acc_shifted[bhp_pkg::ACC_BITS-1:bhp_pkg::Y_BITS-1];

	always_comb begin
		if ((&acc_top) || !(|acc_top)) begin
			yn_d = acc_shifted[bhp_pkg::Y_BITS-1:0];
		end else if (acc_shifted[bhp_pkg::ACC_BITS-1]) begin
			yn_d = bhp_pkg::Y_MIN;
		end else begin
			yn_d = bhp_pkg::Y_MAX;
		end
	end

	// Result: round off the fraction bits and clip to the sample width.
	assign q_base = bhp_pkg::Q_BITS'(yn_q >>> bhp_pkg::FRAC_BITS);
	assign q_rnd  = q_base + bhp_pkg::Q_BITS'(yn_q[bhp_pkg::FRAC_BITS-1]);
	assign q_top  = q_rnd[bhp_pkg::Q_BITS-1:bhp_pkg::SAMPLE_BITS-1];
	assign q_fits = (&q_top) || !(|q_top);

	always_comb begin
		if (q_fits) begin
			res_d = q_rnd[bhp_pkg::SAMPLE_BITS-1:0];
		end else if (q_rnd[bhp_pkg::Q_BITS-1]) begin
			res_d = bhp_pkg::SAMPLE_MIN;
		end else begin
			res_d = bhp_pkg::SAMPLE_MAX;
		end
	end

	// Control state, registers and history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			gain_q      <= bhp_pkg::GAIN_RESET;
			coef_y1_q   <= bhp_pkg::COEF_Y1_RESET;
			coef_y2_q   <= bhp_pkg::COEF_Y2_RESET;
			x_hist1_q   <= '0;
			x_hist2_q   <= '0;
			y_hist1_q   <= '0;
			y_hist2_q   <= '0;
		end else begin
			state_q <= state_d;

			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_idx)
					bhp_pkg::REG_GAIN:    gain_q    <= pwdata[bhp_pkg::GAIN_BITS-1:0];
					bhp_pkg::REG_COEF_Y1: coef_y1_q <= pwdata[bhp_pkg::COEF_BITS-1:0];
					bhp_pkg::REG_COEF_Y2: coef_y2_q <= pwdata[bhp_pkg::COEF_BITS-1:0];
					default: ;
				endcase
			end

			if (finish) begin
				if (pend_q && !keep_q) begin
					x_hist1_q <= '0;
					x_hist2_q <= '0;
					y_hist1_q <= '0;
					y_hist2_q <= '0;
				end else begin
					x_hist2_q <= x_hist1_q;
					x_hist1_q <= xn_q;
					y_hist2_q <= y_hist1_q;
					y_hist1_q <= yn_q;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_ch.sample_in;
			pend_q   <= sample_ch.packet_end;
			keep_q   <= sample_ch.keep_history;
		end

		prod_q <= prod_d;

		if (state_q == ST_MUL_X) begin
			acc_q <= acc_init;
		end else begin
			acc_q <= acc_sum;
		end

		if (state_q == ST_MUL_Y2L) begin
			xn_q <= xn_d;
		end

		if (state_q == ST_NARROW) begin
			yn_q <= yn_d;
		end

		if (finish) begin
			filt_q     <= res_d;
			sat_q      <= !q_fits;
			pend_out_q <= pend_q;
		end
	end

	// A new request always starts the multiply sequence.
	`BHP_ASSERT_NEXT(a_accept_starts, sample_ch.valid && sample_ch.ready, state_q == ST_MUL_X, "accepted request did not start the sequence")

	// A saturated result sits exactly at one of the sample limits.
	`BHP_ASSERT_SAME(a_sat_at_limit, out_valid_q && sat_q, filt_q == bhp_pkg::SAMPLE_MAX || filt_q == bhp_pkg::SAMPLE_MIN, "saturated result is not at a limit")

	// Packet end without keep leaves all history words at zero.
	`BHP_ASSERT_NEXT(a_history_cleared, finish && pend_q && !keep_q, x_hist1_q == '0 && x_hist2_q == '0 && y_hist1_q == '0 && y_hist2_q == '0, "history not cleared at packet end")

	// A result only appears out of the rounding step.
	`BHP_ASSERT_SAME(a_result_source, $rose(out_valid_q), $past(state_q) == ST_ROUND, "result appeared outside the rounding step")

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Biquad high-pass filter unit testbench
// Drives sample requests through the valid/ready channel and loads the
// coefficients over APB. A bit-exact predictor with its own history and
// coefficients computes each filtered sample, and a checker compares every
// result with the oldest prediction. Phases vary the coefficients, sender
// gaps and receiver stalls, and one phase holds the receiver off for a
// long stretch so that the unit fills up and stalls its input.
// ---------------------------------------------------------------------------
module testbench;

	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 40;

	// Register index with no register behind it.
	localparam bhp_pkg::reg_idx_t REG_UNUSED = 2'd3;

	localparam bhp_pkg::gain_t GAIN_TOP    = {bhp_pkg::GAIN_BITS{1'b1}};
	localparam bhp_pkg::coef_t COEF_TOP    = {1'b0, {(bhp_pkg::COEF_BITS-1){1'b1}}};
	localparam bhp_pkg::coef_t COEF_BOTTOM = {1'b1, {(bhp_pkg::COEF_BITS-1){1'b0}}};

	typedef logic signed [127:0] wide_t;

	// One predicted result.
	typedef struct packed {
		bhp_pkg::sample_t filtered;
		logic             saturated;
		logic             pend;
	} filter_out_t;

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [bhp_pkg::CFG_ADDR_BITS-1:0] paddr;
	logic [bhp_pkg::CFG_DATA_BITS-1:0] pwdata;
	logic [bhp_pkg::CFG_DATA_BITS-1:0] prdata;
	logic                              pready;

	bhp_in_if  sample_ch ();
	bhp_out_if result_ch ();

	// Predictor copy of the coefficients and the history words.
	bhp_pkg::gain_t  pred_gain = bhp_pkg::GAIN_RESET;
	bhp_pkg::coef_t  pred_c1   = bhp_pkg::COEF_Y1_RESET;
	bhp_pkg::coef_t  pred_c2   = bhp_pkg::COEF_Y2_RESET;
	bhp_pkg::xhist_t x_prev1   = '0;
	bhp_pkg::xhist_t x_prev2   = '0;
	bhp_pkg::yhist_t y_prev1   = '0;
	bhp_pkg::yhist_t y_prev2   = '0;

	filter_out_t awaited_outputs[$];
	int          fault_count   = 0;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          hold_requests = 0;
	int          holds_served  = 0;

	biquad_highpass_filter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.sample_ch(sample_ch),
		.result_ch(result_ch)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog for a hung run.
	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Clip a value to a signed range of the given width.
	function automatic wide_t clamp_signed(input wide_t v, input int bits);
		wide_t top;
		wide_t bottom;
		top = (128'sd1 <<< (bits - 1)) - 128'sd1;
		bottom = -top - 128'sd1;
		if (v > top)
			return top;
		if (v < bottom)
			return bottom;
		return v;
	endfunction

	// Run one sample through the recursion and advance the history.
	function automatic filter_out_t filter_step(input bhp_pkg::sample_t smp, input logic pend,
		input logic keep);
		wide_t s_w;
		wide_t g_w;
		wide_t xn;
		wide_t xsum;
		wide_t acc;
		wide_t yn;
		wide_t q;
		wide_t res;
		filter_out_t r;
		s_w = smp;
		g_w = pred_gain;
		xn = (s_w * g_w + (128'sd1 <<< (bhp_pkg::SCALE_SHIFT - 1))) >>> bhp_pkg::SCALE_SHIFT;
		xn = clamp_signed(xn, bhp_pkg::X_BITS);
		xsum = xn + wide_t'(x_prev2) - 2 * wide_t'(x_prev1);
		acc = (xsum <<< bhp_pkg::COEF_FRAC) + wide_t'(pred_c2) * wide_t'(y_prev2)
			+ wide_t'(pred_c1) * wide_t'(y_prev1) + (128'sd1 <<< (bhp_pkg::COEF_FRAC - 1));
		acc = acc >>> bhp_pkg::COEF_FRAC;
		yn = clamp_signed(acc, bhp_pkg::Y_BITS);
		q = (yn + (128'sd1 <<< (bhp_pkg::FRAC_BITS - 1))) >>> bhp_pkg::FRAC_BITS;
		res = clamp_signed(q, bhp_pkg::SAMPLE_BITS);
		r.filtered = res[bhp_pkg::SAMPLE_BITS-1:0];
		r.saturated = (res != q);
		r.pend = pend;
		x_prev2 = x_prev1;
		x_prev1 = xn[bhp_pkg::X_BITS-1:0];
		y_prev2 = y_prev1;
		y_prev1 = yn[bhp_pkg::Y_BITS-1:0];
		// A packet end without keep wipes all history after its result.
		if (pend && !keep) begin
			x_prev1 = '0;
			x_prev2 = '0;
			y_prev1 = '0;
			y_prev2 = '0;
		end
		return r;
	endfunction

	// Mostly full-range samples, some small ones and the range ends.
	function automatic bhp_pkg::sample_t random_sample();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return bhp_pkg::sample_t'($urandom);
		if (pick < 85)
			return bhp_pkg::sample_t'(int'($urandom_range(2000)) - 1000);
		if (pick < 90)
			return bhp_pkg::SAMPLE_MAX;
		if (pick < 95)
			return bhp_pkg::SAMPLE_MIN;
		return (pick < 98) ? bhp_pkg::sample_t'(0) : bhp_pkg::sample_t'(-1);
	endfunction

	// Offer one sample request, with random gaps ahead of it, and predict its result.
	task automatic push_sample(input bhp_pkg::sample_t smp, input logic pend, input logic keep);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.sample_in    <= smp;
		sample_ch.packet_end   <= pend;
		sample_ch.keep_history <= keep;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		awaited_outputs.push_back(filter_step(smp, pend, keep));
	endtask

	// Stop offering requests and wait until every result has come back.
	task automatic settle_filter();
		sample_ch.valid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write with random bits above the register width.
	task automatic load_register(input bhp_pkg::reg_idx_t idx, input logic [63:0] value);
		logic [63:0] word;
		word = {$urandom, $urandom};
		case (idx)
			bhp_pkg::REG_GAIN: begin
				word[bhp_pkg::GAIN_BITS-1:0] = value[bhp_pkg::GAIN_BITS-1:0];
				pred_gain = value[bhp_pkg::GAIN_BITS-1:0];
			end
			bhp_pkg::REG_COEF_Y1: begin
				word[bhp_pkg::COEF_BITS-1:0] = value[bhp_pkg::COEF_BITS-1:0];
				pred_c1 = value[bhp_pkg::COEF_BITS-1:0];
			end
			bhp_pkg::REG_COEF_Y2: begin
				word[bhp_pkg::COEF_BITS-1:0] = value[bhp_pkg::COEF_BITS-1:0];
				pred_c2 = value[bhp_pkg::COEF_BITS-1:0];
			end
			default: ;
		endcase
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_defaults();
		load_register(bhp_pkg::REG_GAIN, 64'(bhp_pkg::GAIN_RESET));
		load_register(bhp_pkg::REG_COEF_Y1, 64'(bhp_pkg::COEF_Y1_RESET));
		load_register(bhp_pkg::REG_COEF_Y2, 64'(bhp_pkg::COEF_Y2_RESET));
	endtask

	// Random coefficients inside the stable triangle, so outputs stay mostly in range.
	task automatic load_random_filter();
		int unsigned    c2mag;
		int unsigned    c1mag;
		bhp_pkg::coef_t c1;
		bhp_pkg::coef_t c2;
		c2mag = $urandom_range(32'h2000_0000, 32'h3FF0_0000);
		c1mag = $urandom_range(0, 32'h4000_0000 + c2mag - 32'h0010_0000);
		c1 = bhp_pkg::coef_t'(c1mag);
		if ($urandom_range(1))
			c1 = -c1;
		c2 = bhp_pkg::coef_t'(c2mag);
		c2 = -c2;
		load_register(bhp_pkg::REG_GAIN, 64'($urandom_range(32'h2000_0000, 32'h4800_0000)));
		load_register(bhp_pkg::REG_COEF_Y1, 64'(c1));
		load_register(bhp_pkg::REG_COEF_Y2, 64'(c2));
	endtask

	// Packets of random length; now and then a stray packet end mid-packet.
	task automatic run_traffic(input int count);
		int   sent;
		int   len;
		logic pend;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(1, 40);
			for (int i = 0; i < len && sent < count; i++) begin
				pend = (i == len - 1) || ($urandom_range(99) < 3);
				push_sample(random_sample(), pend, 1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	// Range ends, step saturation and both packet-end flavors at reset coefficients.
	task automatic test_directed_edges();
		send_idle_pct = 0;
		stall_pct = 0;
		push_sample(bhp_pkg::SAMPLE_MAX, 1'b0, 1'b0);
		push_sample(bhp_pkg::SAMPLE_MAX, 1'b0, 1'b1);
		push_sample(bhp_pkg::SAMPLE_MIN, 1'b0, 1'b0);
		push_sample(bhp_pkg::SAMPLE_MAX, 1'b0, 1'b0);
		push_sample(bhp_pkg::SAMPLE_MIN, 1'b0, 1'b0);
		push_sample(bhp_pkg::sample_t'(0), 1'b1, 1'b1);
		push_sample(bhp_pkg::sample_t'(-1), 1'b0, 1'b0);
		push_sample(bhp_pkg::sample_t'(1), 1'b0, 1'b1);
		push_sample(bhp_pkg::SAMPLE_MIN, 1'b1, 1'b0);
		push_sample(bhp_pkg::SAMPLE_MIN, 1'b0, 1'b1);
		push_sample(bhp_pkg::sample_t'(24'h555555), 1'b0, 1'b0);
		push_sample(bhp_pkg::sample_t'(24'hAAAAAA), 1'b0, 1'b0);
		push_sample(bhp_pkg::sample_t'(0), 1'b1, 1'b0);
		push_sample(bhp_pkg::sample_t'(0), 1'b0, 1'b0);
	endtask

	// Register extremes drive the history into saturation; a stray index is ignored.
	task automatic test_register_extremes();
		settle_filter();
		load_register(bhp_pkg::REG_GAIN, 64'(GAIN_TOP));
		load_register(bhp_pkg::REG_COEF_Y1, 64'(COEF_TOP));
		load_register(bhp_pkg::REG_COEF_Y2, 64'(COEF_BOTTOM));
		load_register(REG_UNUSED, {$urandom, $urandom});
		push_sample(bhp_pkg::SAMPLE_MAX, 1'b0, 1'b0);
		push_sample(bhp_pkg::SAMPLE_MIN, 1'b0, 1'b0);
		push_sample(bhp_pkg::SAMPLE_MAX, 1'b0, 1'b0);
		push_sample(bhp_pkg::SAMPLE_MIN, 1'b0, 1'b0);
		push_sample(bhp_pkg::SAMPLE_MAX, 1'b0, 1'b0);
		settle_filter();
		load_register(bhp_pkg::REG_GAIN, '0);
		load_register(bhp_pkg::REG_COEF_Y1, 64'(COEF_BOTTOM));
		load_register(bhp_pkg::REG_COEF_Y2, 64'(COEF_TOP));
		push_sample(bhp_pkg::SAMPLE_MAX, 1'b0, 1'b0);
		push_sample(bhp_pkg::SAMPLE_MIN, 1'b0, 1'b0);
		push_sample(bhp_pkg::sample_t'(-1), 1'b0, 1'b0);
		// Clear the saturated history for the phases that follow.
		push_sample(bhp_pkg::SAMPLE_MAX, 1'b1, 1'b0);
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		settle_filter();
		load_defaults();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_requests <= hold_requests + 1;
		repeat (30) push_sample(random_sample(), 1'b0, 1'($urandom_range(1)));
		push_sample(random_sample(), 1'b1, 1'b0);
	endtask

	// Random packets under several coefficient sets and idling mixes.
	task automatic test_random_phases();
		settle_filter();
		load_defaults();
		send_idle_pct = 0;
		stall_pct = 0;
		run_traffic(215);
		settle_filter();
		load_random_filter();
		send_idle_pct = 85;
		stall_pct = 0;
		run_traffic(215);
		settle_filter();
		load_random_filter();
		send_idle_pct = 0;
		stall_pct = 85;
		run_traffic(215);
		settle_filter();
		load_register(bhp_pkg::REG_GAIN, 64'($urandom_range(32'h2000_0000, 32'h4800_0000)));
		load_register(bhp_pkg::REG_COEF_Y1, 64'(bhp_pkg::COEF_Y1_RESET));
		send_idle_pct = 24;
		stall_pct = 24;
		run_traffic(215);
	endtask

	// Receiver ready: random stalls, plus a long hold-off when one is requested.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		filter_out_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (awaited_outputs.size() == 0) begin
				fault_count++;
				$display("%0t: result with none expected: filtered_out=%0d saturated=%0b packet_end_out=%0b",
					$time, result_ch.filtered_out, result_ch.saturated, result_ch.packet_end_out);
			end else begin
				want = awaited_outputs.pop_front();
				if (result_ch.filtered_out !== want.filtered
					|| result_ch.saturated !== want.saturated
					|| result_ch.packet_end_out !== want.pend) begin
					fault_count++;
					$display("%0t: expected filtered_out=%0d saturated=%0b packet_end_out=%0b, got %0d %0b %0b",
						$time, want.filtered, want.saturated, want.pend,
						result_ch.filtered_out, result_ch.saturated, result_ch.packet_end_out);
				end
			end
		end
	end

	// Reset, then the tests in turn.
	initial begin
		arst_n                 <= 1'b0;
		psel                   <= 1'b0;
		penable                <= 1'b0;
		pwrite                 <= 1'b0;
		paddr                  <= '0;
		pwdata                 <= '0;
		sample_ch.valid        <= 1'b0;
		sample_ch.sample_in    <= '0;
		sample_ch.packet_end   <= 1'b0;
		sample_ch.keep_history <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_edges();
		test_register_extremes();
		test_backpressure();
		test_random_phases();
		settle_filter();
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== biquad_highpass_filter_unit.f =====
+incdir+rtl/core
rtl/core/bhp_pkg.sv
rtl/core/bhp_if.sv
rtl/core/biquad_highpass_filter_unit.sv
test/testbench.sv
